// ===== design/imu_bias_calibrate_and_smooth_macros.svh =====
// assertion macros shared by the checker of the imu bias and smoothing block
`ifndef IMU_BIAS_CALIBRATE_AND_SMOOTH_MACROS_SVH
`define IMU_BIAS_CALIBRATE_AND_SMOOTH_MACROS_SVH

// same-cycle implication, ignored while reset is held
`define IBCS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ibcs: same-cycle check failed");

// next-cycle implication, ignored while reset is held
`define IBCS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ibcs: next-cycle check failed");

// next-cycle implication that is also checked across reset
`define IBCS_ASSERT_NXT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("ibcs: reset check failed");

`endif

// ===== design/ibcs_pkg.sv =====
// shared types, constants and constant dividers of the imu bias and smoothing block
package ibcs_pkg;

    // number of samples averaged for one gyro bias
    localparam int CAL_SAMPLES = 100;

    typedef logic signed [15:0] t_sample;
    typedef logic signed [23:0] t_sum;
    typedef logic [7:0]         t_count;
    // weighted three-tap sum, magnitude at most 100 * 32768
    typedef logic signed [22:0] t_wsum;

    // calibration status handed from the calibration unit to the datapath
    typedef struct packed {
        logic active;
        logic ready;
        logic last;
    } t_cal_status;

    // filter weights in hundredths
    localparam t_wsum W_AZ_NOW  = 23'sd90;
    localparam t_wsum W_AZ_PREV = 23'sd5;
    localparam t_wsum W_AZ_OLD  = 23'sd5;
    localparam t_wsum W_GY_NOW  = 23'sd92;
    localparam t_wsum W_GY_PREV = 23'sd5;
    localparam t_wsum W_GY_OLD  = 23'sd3;
    localparam t_wsum W_GZ_NOW  = 23'sd90;
    localparam t_wsum W_GZ_PREV = 23'sd5;
    localparam t_wsum W_GZ_OLD  = 23'sd5;

    // reciprocals: ceil(2^30 / 100) and ceil(2^32 / CAL_SAMPLES)
    localparam logic [23:0] HUND_RECIP =
        24'(((64'd1 << 30) + 64'd99) / 64'd100);
    localparam logic [32:0] CAL_RECIP =
        33'(((64'd1 << 32) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

    // weighted sum / 100, truncated toward zero
    function automatic t_sample div_hundred(input t_wsum v);
        logic [21:0] mag;
        logic [45:0] prod;
        logic [15:0] q;
        mag  = v[22] ? 22'(-v) : 22'(v);
        prod = 46'(mag) * 46'(HUND_RECIP);
        q    = prod[45:30];
        return v[22] ? t_sample'(-q) : t_sample'(q);
    endfunction

    // calibration sum / CAL_SAMPLES, truncated toward zero
    function automatic t_sample div_cal(input t_sum s);
        logic [23:0] mag;
        logic [56:0] prod;
        logic [15:0] q;
        mag  = s[23] ? 24'(-s) : 24'(s);
        prod = 57'(mag) * 57'(CAL_RECIP);
        q    = prod[47:32];
        return s[23] ? t_sample'(-q) : t_sample'(q);
    endfunction

endpackage

// ===== design/ibcs_in_if.sv =====
// input channel: one six-axis sample or a start-calibration command per item
interface ibcs_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    ibcs_pkg::t_sample  raw_acc_x;
    ibcs_pkg::t_sample  raw_acc_y;
    ibcs_pkg::t_sample  raw_acc_z;
    ibcs_pkg::t_sample  raw_gyro_x;
    ibcs_pkg::t_sample  raw_gyro_y;
    ibcs_pkg::t_sample  raw_gyro_z;

    modport source (
        output valid, func, raw_acc_x, raw_acc_y, raw_acc_z,
               raw_gyro_x, raw_gyro_y, raw_gyro_z,
        input  ready
    );
    modport sink (
        input  valid, func, raw_acc_x, raw_acc_y, raw_acc_z,
               raw_gyro_x, raw_gyro_y, raw_gyro_z,
        output ready
    );
endinterface

// ===== design/ibcs_out_if.sv =====
// output channel: corrected and smoothed sample with calibration flags
interface ibcs_out_if;
    logic               valid;
    logic               ready;
    ibcs_pkg::t_sample  acc_x_out;
    ibcs_pkg::t_sample  acc_y_out;
    ibcs_pkg::t_sample  acc_z_smooth;
    ibcs_pkg::t_sample  gyro_x_out;
    ibcs_pkg::t_sample  gyro_y_smooth;
    ibcs_pkg::t_sample  gyro_z_smooth;
    logic               calibrating;
    logic               bias_valid;

    modport source (
        output valid, acc_x_out, acc_y_out, acc_z_smooth, gyro_x_out,
               gyro_y_smooth, gyro_z_smooth, calibrating, bias_valid,
        input  ready
    );
    modport sink (
        input  valid, acc_x_out, acc_y_out, acc_z_smooth, gyro_x_out,
               gyro_y_smooth, gyro_z_smooth, calibrating, bias_valid,
        output ready
    );
endinterface

// ===== design/ibcs_cal.sv =====
// gyro bias calibration: per-axis sums, sample count and latched bias
module ibcs_cal (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_func,
    input  ibcs_pkg::t_sample     i_gyro [3],
    output ibcs_pkg::t_sample     o_bias [3],
    output ibcs_pkg::t_cal_status o_status
);
    import ibcs_pkg::*;

    logic    r_active, n_active;
    logic    r_ready, n_ready;
    t_count  r_count, n_count;
    t_sum    r_sum [3];
    t_sum    n_sum [3];
    t_sample r_bias [3];
    t_sample n_bias [3];
    logic    last;

    // this sample completes the calibration
    assign last = ({1'b0, r_count} + 9'd1) >= 9'(CAL_SAMPLES);

    // next state for one accepted item
    always_comb begin
        n_active = r_active;
        n_ready  = r_ready;
        n_count  = r_count;
        n_sum    = r_sum;
        n_bias   = r_bias;
        if (i_step) begin
            if (i_func) begin
                n_active = 1'b1;
                n_ready  = 1'b0;
                n_count  = '0;
                for (int i = 0; i < 3; i++) begin
                    n_sum[i]  = '0;
                    n_bias[i] = '0;
                end
            end else if (r_active) begin
                n_count = r_count + 8'd1;
                for (int i = 0; i < 3; i++) begin
                    n_sum[i] = r_sum[i] + t_sum'(i_gyro[i]);
                end
                if (last) begin
                    n_active = 1'b0;
                    n_ready  = 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        n_bias[i] = div_cal(n_sum[i]);
                    end
                end
            end
        end
    end

    // state registers, all cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_ready  <= 1'b0;
            r_count  <= '0;
            for (int i = 0; i < 3; i++) begin
                r_sum[i]  <= '0;
                r_bias[i] <= '0;
            end
        end else begin
            r_active <= n_active;
            r_ready  <= n_ready;
            r_count  <= n_count;
            r_sum    <= n_sum;
            r_bias   <= n_bias;
        end
    end

    assign o_bias          = r_bias;
    assign o_status.active = r_active;
    assign o_status.ready  = r_ready;
    assign o_status.last   = last;

endmodule

// ===== design/imu_bias_calibrate_and_smooth.sv =====
// top level: imu gyro bias calibration, bias removal and three-tap smoothing
//
//  channel  | dir | content
//  ---------+-----+----------------------------------------------------------
//  i_in     | in  | func, raw accel x/y/z, raw gyro x/y/z
//  o_out    | out | accel x/y, smoothed accel z, gyro x, smoothed gyro y/z, flags
//
// one item per cycle sustained while results are taken; each item passes through the input
// register, the weighted-sum register and the result register in that order.
// the longest path is the bias division by reciprocal multiply on the last
// calibration sample, and the divide by 100 of the weighted sums.
// reset clears bias, sums, count, flags, histories and all valid bits.
// a stalled result holds all stages; items keep flowing into empty stages.
module imu_bias_calibrate_and_smooth (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ibcs_in_if.sink    i_in,
    ibcs_out_if.source o_out
);
    import ibcs_pkg::*;

    // pipeline control
    logic out_free, mid_adv, mid_free, s1_adv, in_acc;

    // input register
    logic    r_s1_vld;
    logic    r_s1_func;
    t_sample r_s1_ax, r_s1_ay, r_s1_az;
    t_sample r_s1_g [3];

    // weighted-sum register
    logic    r_m_vld;
    logic    r_m_filt;
    logic    r_m_cal;
    logic    r_m_bias_valid;
    t_sample r_m_ax, r_m_ay, r_m_gx;
    t_sample r_m_pass [3];
    t_wsum   r_m_wsum [3];

    // result register
    logic    r_o_vld;
    logic    r_o_cal;
    logic    r_o_bias_valid;
    t_sample r_o_ax, r_o_ay, r_o_az, r_o_gx, r_o_gy, r_o_gz;

    // filter histories: index 1 previous, index 0 the one before
    t_sample r_hist_az [2];
    t_sample r_hist_gy [2];
    t_sample r_hist_gz [2];

    // calibration unit
    t_sample     bias [3];
    t_cal_status cal_st;

    // first-stage datapath
    t_sample g_corr [3];
    logic    is_cmd, is_cal, is_filt;
    logic    bias_valid_next;
    t_wsum   wsum [3];

    // handshake chain
    assign out_free   = !r_o_vld || o_out.ready;
    assign mid_adv    = r_m_vld && out_free;
    assign mid_free   = !r_m_vld || mid_adv;
    assign s1_adv     = r_s1_vld && mid_free;
    assign i_in.ready = !r_s1_vld || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;

    ibcs_cal u_cal (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_adv),
        .i_func   (r_s1_func),
        .i_gyro   (r_s1_g),
        .o_bias   (bias),
        .o_status (cal_st)
    );

    // item kind and flags
    assign is_cmd  = r_s1_func;
    assign is_cal  = !r_s1_func && cal_st.active;
    assign is_filt = !r_s1_func && !cal_st.active;

    always_comb begin
        if (is_cmd) begin
            bias_valid_next = 1'b0;
        end else if (is_cal) begin
            bias_valid_next = cal_st.ready || cal_st.last;
        end else begin
            bias_valid_next = cal_st.ready;
        end
    end

    // bias removal, wrapping to 16 bits
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            g_corr[i] = r_s1_g[i] - bias[i];
        end
    end

    // weighted three-tap sums
    assign wsum[0] = t_wsum'(r_s1_az) * W_AZ_NOW
                   + t_wsum'(r_hist_az[1]) * W_AZ_PREV
                   + t_wsum'(r_hist_az[0]) * W_AZ_OLD;
    assign wsum[1] = t_wsum'(g_corr[1]) * W_GY_NOW
                   + t_wsum'(r_hist_gy[1]) * W_GY_PREV
                   + t_wsum'(r_hist_gy[0]) * W_GY_OLD;
    assign wsum[2] = t_wsum'(g_corr[2]) * W_GZ_NOW
                   + t_wsum'(r_hist_gz[1]) * W_GZ_PREV
                   + t_wsum'(r_hist_gz[0]) * W_GZ_OLD;

    // valid bits and filter history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_m_vld  <= 1'b0;
            r_o_vld  <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_hist_az[i] <= '0;
                r_hist_gy[i] <= '0;
                r_hist_gz[i] <= '0;
            end
        end else begin
            if (i_in.ready) begin
                r_s1_vld <= i_in.valid;
            end
            if (mid_free) begin
                r_m_vld <= r_s1_vld;
            end
            if (out_free) begin
                r_o_vld <= r_m_vld;
            end
            if (s1_adv && is_filt) begin
                r_hist_az[0] <= r_hist_az[1];
                r_hist_az[1] <= r_s1_az;
                r_hist_gy[0] <= r_hist_gy[1];
                r_hist_gy[1] <= g_corr[1];
                r_hist_gz[0] <= r_hist_gz[1];
                r_hist_gz[1] <= g_corr[2];
            end
        end
    end

    // input payload register
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_func <= i_in.func;
            r_s1_ax   <= i_in.raw_acc_x;
            r_s1_ay   <= i_in.raw_acc_y;
            r_s1_az   <= i_in.raw_acc_z;
            r_s1_g[0] <= i_in.raw_gyro_x;
            r_s1_g[1] <= i_in.raw_gyro_y;
            r_s1_g[2] <= i_in.raw_gyro_z;
        end
    end

    // weighted-sum payload register
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_m_filt       <= is_filt;
            r_m_cal        <= !is_filt;
            r_m_bias_valid <= bias_valid_next;
            r_m_wsum       <= wsum;
            if (is_cmd) begin
                r_m_ax <= '0;
                r_m_ay <= '0;
                r_m_gx <= '0;
                for (int i = 0; i < 3; i++) begin
                    r_m_pass[i] <= '0;
                end
            end else begin
                r_m_ax      <= r_s1_ax;
                r_m_ay      <= r_s1_ay;
                r_m_gx      <= g_corr[0];
                r_m_pass[0] <= r_s1_az;
                r_m_pass[1] <= r_s1_g[1];
                r_m_pass[2] <= r_s1_g[2];
            end
        end
    end

    // result register: divide the sums by 100, or pass raw values (zero for a start command)
    always_ff @(posedge i_clk) begin
        if (mid_adv) begin
            r_o_ax         <= r_m_ax;
            r_o_ay         <= r_m_ay;
            r_o_gx         <= r_m_gx;
            r_o_cal        <= r_m_cal;
            r_o_bias_valid <= r_m_bias_valid;
            if (r_m_filt) begin
                r_o_az <= div_hundred(r_m_wsum[0]);
                r_o_gy <= div_hundred(r_m_wsum[1]);
                r_o_gz <= div_hundred(r_m_wsum[2]);
            end else begin
                r_o_az <= r_m_pass[0];
                r_o_gy <= r_m_pass[1];
                r_o_gz <= r_m_pass[2];
            end
        end
    end

    assign o_out.valid         = r_o_vld;
    assign o_out.acc_x_out     = r_o_ax;
    assign o_out.acc_y_out     = r_o_ay;
    assign o_out.acc_z_smooth  = r_o_az;
    assign o_out.gyro_x_out    = r_o_gx;
    assign o_out.gyro_y_smooth = r_o_gy;
    assign o_out.gyro_z_smooth = r_o_gz;
    assign o_out.calibrating   = r_o_cal;
    assign o_out.bias_valid    = r_o_bias_valid;

endmodule

// ===== design/ibcs_checker.sv =====
// port-level checks of the imu bias and smoothing block, bound to the top level
`include "imu_bias_calibrate_and_smooth_macros.svh"

module ibcs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);
    logic       in_acc, out_acc;
    logic [2:0] r_inflight;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // items taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 3'(in_acc) - 3'(out_acc);
        end
    end

    // reset empties the result register
    `IBCS_ASSERT_NXT_RST(a_rst_empties, !i_rst_n, !i_out_valid)
    // a waiting result is not withdrawn
    `IBCS_ASSERT_NXT(a_out_holds, i_out_valid && !i_out_ready, i_out_valid)
    // no result without an item in flight
    `IBCS_ASSERT_IMP(a_no_phantom, i_out_valid, r_inflight != 3'd0)
    // the three stages never hold more than three items
    `IBCS_ASSERT_IMP(a_capacity, in_acc && !out_acc, r_inflight <= 3'd2)

endmodule

bind imu_bias_calibrate_and_smooth ibcs_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready)
);

// ===== verif/tb_imu_bias_calibrate_and_smooth.sv =====
// self-checking testbench for the imu bias calibration and smoothing block
`timescale 1ns / 100ps

module tb_imu_bias_calibrate_and_smooth;
    import ibcs_pkg::*;

    // item codes
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_START  = 1'b1;

    localparam int N_DIRECTED       = 14;
    localparam int N_RANDOM         = 550;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int HOLD_CYCLES      = 120;
    localparam int HOLD_AFTER_ITEMS = 250;
    localparam int MAX_REPORTS      = 10;

    localparam t_sample MAXV = 16'sh7FFF;
    localparam t_sample MINV = 16'sh8000;

    typedef struct packed {
        t_sample acc_x;
        t_sample acc_y;
        t_sample acc_z;
        t_sample gyro_x;
        t_sample gyro_y;
        t_sample gyro_z;
        logic    calibrating;
        logic    bias_valid;
    } t_result;

    typedef struct packed {
        logic    func;
        t_sample acc_x;
        t_sample acc_y;
        t_sample acc_z;
        t_sample gyro_x;
        t_sample gyro_y;
        t_sample gyro_z;
        logic    typed;
        t_result want;
    } t_stim;

    localparam t_result ALL_ZERO  = '0;
    localparam t_result START_ACK = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                                      1'b1, 1'b0};

    // directed items: extremes, start commands, restart during calibration
    localparam t_stim DIRECTED [N_DIRECTED] = '{
        '{FUNC_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, ALL_ZERO},
        '{FUNC_SAMPLE, MAXV, MINV, MAXV, MAXV, MAXV, MAXV, 1'b0, ALL_ZERO},
        '{FUNC_SAMPLE, MINV, MINV, MINV, MINV, MINV, MINV, 1'b0, ALL_ZERO},
        '{FUNC_SAMPLE, MINV, MAXV, MINV, MINV, MINV, MINV, 1'b0, ALL_ZERO},
        '{FUNC_SAMPLE, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF,
          1'b0, ALL_ZERO},
        '{FUNC_SAMPLE, 16'sh0001, 16'shFFFF, 16'shFFFF, 16'sh0001, 16'sh0001, 16'shFFFF,
          1'b0, ALL_ZERO},
        '{FUNC_START, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 1'b1, START_ACK},
        '{FUNC_SAMPLE, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 1'b1,
          '{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 1'b1, 1'b0}},
        '{FUNC_SAMPLE, MINV, MINV, MINV, MINV, MINV, MINV, 1'b1,
          '{MINV, MINV, MINV, MINV, MINV, MINV, 1'b1, 1'b0}},
        '{FUNC_SAMPLE, 16'sh1234, 16'shEDCC, 16'sh0F0F, 16'shF0F0, 16'sh5555, 16'shAAAA,
          1'b1, '{16'sh1234, 16'shEDCC, 16'sh0F0F, 16'shF0F0, 16'sh5555, 16'shAAAA,
                  1'b1, 1'b0}},
        '{FUNC_START, MINV, MINV, MINV, MINV, MINV, MINV, 1'b1, START_ACK},
        '{FUNC_SAMPLE, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF,
          1'b1, '{16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF,
                  1'b1, 1'b0}},
        '{FUNC_SAMPLE, 16'sh5A5A, 16'shA5A5, 16'sh5A5A, 16'shA5A5, 16'sh5A5A, 16'shA5A5,
          1'b1, '{16'sh5A5A, 16'shA5A5, 16'sh5A5A, 16'shA5A5, 16'sh5A5A, 16'shA5A5,
                  1'b1, 1'b0}},
        '{FUNC_START, 16'sh00FF, 16'shFF00, 16'sh00FF, 16'shFF00, 16'sh00FF, 16'shFF00,
          1'b1, START_ACK}
    };

    logic i_clk;
    logic i_rst_n;

    ibcs_in_if  in_ch ();
    ibcs_out_if out_ch ();

    imu_bias_calibrate_and_smooth uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // predictor state: bias, calibration sums and filter taps
    int bias_q [3];
    int cal_sum [3];
    int cal_count;
    bit cal_on;
    bit bias_ok;
    int az_prev, az_old;
    int gy_prev, gy_old;
    int gz_prev, gz_old;

    t_result pending_results [$];

    int  items_taken;
    int  results_checked;
    int  fail_count;
    int  start_count;
    int  calibrations_done;
    int  cycle_count;
    int  quiet_left;
    int  held;
    bit  hold_done;

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // three-tap weighted sum in hundredths, shifting the taps along
    function automatic int smooth3(inout int prev, inout int old, input int now,
                                   input int w_now, input int w_prev, input int w_old);
        int acc;
        acc  = w_now * now + w_prev * prev + w_old * old;
        old  = prev;
        prev = now;
        return acc / 100;
    endfunction

    // expected result of one item, advancing the predictor state
    function automatic t_result imu_predict(input t_stim s);
        t_result r;
        int      g [3];
        t_sample w;
        int      i;
        r    = '0;
        g[0] = s.gyro_x;
        g[1] = s.gyro_y;
        g[2] = s.gyro_z;
        if (s.func == FUNC_START) begin
            for (i = 0; i < 3; i++) begin
                bias_q[i]  = 0;
                cal_sum[i] = 0;
            end
            cal_count     = 0;
            cal_on        = 1'b1;
            bias_ok       = 1'b0;
            r.calibrating = 1'b1;
            start_count++;
        end else if (cal_on) begin
            for (i = 0; i < 3; i++) cal_sum[i] += g[i];
            cal_count++;
            if (cal_count >= CAL_SAMPLES) begin
                for (i = 0; i < 3; i++) bias_q[i] = cal_sum[i] / CAL_SAMPLES;
                bias_ok = 1'b1;
                cal_on  = 1'b0;
                calibrations_done++;
            end
            r.acc_x       = s.acc_x;
            r.acc_y       = s.acc_y;
            r.acc_z       = s.acc_z;
            r.gyro_x      = s.gyro_x;
            r.gyro_y      = s.gyro_y;
            r.gyro_z      = s.gyro_z;
            r.calibrating = 1'b1;
            r.bias_valid  = bias_ok;
        end else begin
            // bias removal wraps to 16 bits
            for (i = 0; i < 3; i++) begin
                w    = t_sample'(g[i] - bias_q[i]);
                g[i] = w;
            end
            r.acc_x  = s.acc_x;
            r.acc_y  = s.acc_y;
            r.acc_z  = t_sample'(smooth3(az_prev, az_old, s.acc_z,
                                         W_AZ_NOW, W_AZ_PREV, W_AZ_OLD));
            r.gyro_x = t_sample'(g[0]);
            r.gyro_y = t_sample'(smooth3(gy_prev, gy_old, g[1],
                                         W_GY_NOW, W_GY_PREV, W_GY_OLD));
            r.gyro_z = t_sample'(smooth3(gz_prev, gz_old, g[2],
                                         W_GZ_NOW, W_GZ_PREV, W_GZ_OLD));
            r.calibrating = 1'b0;
            r.bias_valid  = bias_ok;
        end
        return r;
    endfunction

    // idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // value around a centre, saturated to 16 bits
    function automatic t_sample near_value(input int centre, input int spread);
        int v;
        v = centre + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return t_sample'(v);
    endfunction

    // offer one item, book its expected result on acceptance, then idle for a random gap that may be empty
    task automatic offer_item(input t_stim s);
        t_result want;
        int      gap;
        in_ch.valid      <= 1'b1;
        in_ch.func       <= s.func;
        in_ch.raw_acc_x  <= s.acc_x;
        in_ch.raw_acc_y  <= s.acc_y;
        in_ch.raw_acc_z  <= s.acc_z;
        in_ch.raw_gyro_x <= s.gyro_x;
        in_ch.raw_gyro_y <= s.gyro_y;
        in_ch.raw_gyro_z <= s.gyro_z;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        want = imu_predict(s);
        if (s.typed) want = s.want;
        pending_results.push_back(want);
        items_taken++;
        if (quiet_left > 0) begin
            quiet_left--;
            gap = 0;
        end else if ($urandom_range(0, 24) == 0) begin
            quiet_left = $urandom_range(20, 50);
            gap = 0;
        end else begin
            gap = pick_gap();
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got.acc_x       = out_ch.acc_x_out;
            got.acc_y       = out_ch.acc_y_out;
            got.acc_z       = out_ch.acc_z_smooth;
            got.gyro_x      = out_ch.gyro_x_out;
            got.gyro_y      = out_ch.gyro_y_smooth;
            got.gyro_z      = out_ch.gyro_z_smooth;
            got.calibrating = out_ch.calibrating;
            got.bias_valid  = out_ch.bias_valid;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result at cycle %0d", cycle_count);
            end else begin
                want = pending_results.pop_front();
                if (got.acc_x !== want.acc_x || got.acc_y !== want.acc_y ||
                    got.acc_z !== want.acc_z || got.gyro_x !== want.gyro_x ||
                    got.gyro_y !== want.gyro_y || got.gyro_z !== want.gyro_z ||
                    got.calibrating !== want.calibrating ||
                    got.bias_valid !== want.bias_valid) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("result %0d wrong: exp ax %0d ay %0d az %0d gx %0d gy %0d gz %0d cal %0b bv %0b",
                                 results_checked, want.acc_x, want.acc_y, want.acc_z,
                                 want.gyro_x, want.gyro_y, want.gyro_z,
                                 want.calibrating, want.bias_valid);
                        $display("    got ax %0d ay %0d az %0d gx %0d gy %0d gz %0d cal %0b bv %0b",
                                 got.acc_x, got.acc_y, got.acc_z, got.gyro_x, got.gyro_y,
                                 got.gyro_z, got.calibrating, got.bias_valid);
                    end
                end
            end
            results_checked++;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random ready, with one long hold-off to back the block up
    initial begin : result_sink
        int run;
        int gap;
        out_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (!hold_done && items_taken >= HOLD_AFTER_ITEMS) begin
                hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge i_clk);
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
            out_ch.ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        t_stim s;
        int    centre [3];
        int    spread;
        int    cal_left;
        int    n;
        int    i;
        bit    do_start;
        in_ch.valid      <= 1'b0;
        in_ch.func       <= FUNC_SAMPLE;
        in_ch.raw_acc_x  <= '0;
        in_ch.raw_acc_y  <= '0;
        in_ch.raw_acc_z  <= '0;
        in_ch.raw_gyro_x <= '0;
        in_ch.raw_gyro_y <= '0;
        in_ch.raw_gyro_z <= '0;
        i_rst_n          <= 1'b0;
        centre   = '{0, 0, 0};
        spread   = 0;
        cal_left = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        for (n = 0; n < N_DIRECTED; n++) offer_item(DIRECTED[n]);

        // random part: calibrations with random offsets, then corrected samples
        for (n = 0; n < N_RANDOM; n++) begin
            s       = '0;
            s.acc_x = t_sample'($urandom());
            s.acc_y = t_sample'($urandom());
            if (n == 0)
                do_start = 1'b1;
            else if (cal_left > 0)
                do_start = ($urandom_range(0, 299) == 0);
            else
                do_start = ($urandom_range(0, 69) == 0);
            if (do_start) begin
                s.func   = FUNC_START;
                s.acc_z  = t_sample'($urandom());
                s.gyro_x = t_sample'($urandom());
                s.gyro_y = t_sample'($urandom());
                s.gyro_z = t_sample'($urandom());
                cal_left = CAL_SAMPLES;
                // offsets near both rails as well as anywhere in range
                for (i = 0; i < 3; i++) begin
                    case ($urandom_range(0, 3))
                        0: centre[i] = 32767 - int'($urandom_range(0, 800));
                        1: centre[i] = -32768 + int'($urandom_range(0, 800));
                        default: centre[i] = int'(t_sample'($urandom()));
                    endcase
                end
                case ($urandom_range(0, 3))
                    0: spread = 0;
                    1: spread = 15;
                    2: spread = 600;
                    default: spread = 32767;
                endcase
            end else begin
                s.func  = FUNC_SAMPLE;
                s.acc_z = ($urandom_range(0, 9) < 6) ? t_sample'($urandom())
                                                     : near_value(centre[0], 50);
                if (cal_left > 0 || $urandom_range(0, 9) < 7) begin
                    s.gyro_x = near_value(centre[0], spread);
                    s.gyro_y = near_value(centre[1], spread);
                    s.gyro_z = near_value(centre[2], spread);
                end else begin
                    s.gyro_x = t_sample'($urandom());
                    s.gyro_y = t_sample'($urandom());
                    s.gyro_z = t_sample'($urandom());
                end
                if (cal_left > 0) cal_left--;
            end
            offer_item(s);
        end
        in_ch.valid <= 1'b0;

        // drain
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d items, %0d start commands, %0d completed calibrations",
                 items_taken, start_count, calibrations_done);
        $display("%0d results checked, %0d failures, output held off for %0d cycles once",
                 results_checked, fail_count, held);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
